// ===== sv/scr_pkg.sv =====
// Shared types and constants for the serial command responder.
// Used by the front end, the command queue, the back end and the top level.
// No dependencies.
package scr_pkg;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned NDIGITS  = 4;
  localparam int unsigned DIDX_W   = $clog2(NDIGITS);
  localparam int unsigned DCNT_W   = $clog2(NDIGITS + 1);

  // Stream payload widths (packed fields padded to whole bytes)
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 16;

  // Command queue geometry
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Input item kinds (in_tuser)
  localparam logic OP_BYTE   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // ASCII command and reply codes
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [BYTE_W-1:0] CH_ONE   = 8'h31;  // '1'
  localparam logic [BYTE_W-1:0] CH_QUERY = 8'h3F;  // '?'
  localparam logic [BYTE_W-1:0] CH_UPPL  = 8'h4C;  // 'L'
  localparam logic [BYTE_W-1:0] CH_LOWL  = 8'h6C;  // 'l'

  // Divide-by-ten: q = (v * DIV10_MUL) >> DIV10_SHIFT, exact for v < 1029
  localparam int unsigned          DIV10_MUL_W = 8;
  localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 8'd205;
  localparam int unsigned          DIV10_SHIFT = 11;
  localparam int unsigned          PROD_W      = SAMPLE_W + DIV10_MUL_W;
  localparam int unsigned          QUOT_W      = PROD_W - DIV10_SHIFT;

  // What the back end has to do for one item
  typedef enum logic [1:0] {
    KIND_NONE,   // nothing to send, one idle result
    KIND_FLAG,   // send '1' or '0' for the LED flag
    KIND_NUM     // send the stored sample in decimal
  } kind_t;

  // One queued command
  typedef struct packed {
    kind_t                kind;
    logic                 led;
    logic [SAMPLE_W-1:0]  value;
  } cmd_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_EMIT
  } bk_state_t;

endpackage

// ===== sv/serial_command_responder_unit.sv =====
// Top level of the serial command responder.
// Instantiates scr_front, scr_queue and scr_back; uses scr_pkg.
//
// Each input transfer is a received byte (in_tuser 0) or a new light-sensor
// sample (in_tuser 1). Samples are stored; '1' and '0' set and clear the LED
// flag; '?' replies with '1' or '0'; 'L' or 'l' replies with the stored
// sample as 1 to 4 decimal ASCII digits, most significant first. Every item
// gives at least one result; out_tuser marks a byte to transmit, out_tlast
// the final result of an item, and out_tdata[8] carries the LED flag after
// that item. The front end takes one item per cycle while the two-entry
// command queue has room. The back end answers an item with a single result
// directly from idle; a decimal reply of d digits (up to 4) takes one
// divide-by-ten step per digit, then one result per digit sent, using the
// shared reciprocal divider and the single result register.
module serial_command_responder_unit import scr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] rx_byte, [17:8] sample
  input  logic                   in_tuser,   // [0] op
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] tx_byte, [8] led_on
  output logic                   out_tuser,  // [0] tx_valid
  output logic                   out_tlast
);

  q_status_t q_status;
  logic      push;
  logic      pop;
  cmd_t      push_cmd;
  cmd_t      head;

  scr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_status  (q_status),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  scr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  scr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Checks

  // An idle result is always the only result of its item and carries zero
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && out_tdata[BYTE_W-1:0] == '0)
    else $error("idle result not final or not zero");

  // Transmitted bytes are always ASCII digits
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[BYTE_W-1:0] >= CH_ZERO && out_tdata[BYTE_W-1:0] <= (CH_ZERO + 8'd9))
    else $error("transmitted byte is not a digit");

  // The queue is never written when full nor read when empty
  a_queue_safe: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_status.full) && !(pop && q_status.empty))
    else $error("command queue overflow or underflow");

  // A stalled result holds its last flag until taken
  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tlast))
    else $error("result changed while stalled");

endmodule

// ===== sv/scr_front.sv =====
// Front end: accepts input items, keeps the LED flag and sensor sample,
// and pushes one classified command per item into the queue. Uses scr_pkg.
module scr_front import scr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // [7:0] rx_byte, [17:8] sample
  input  logic                  in_tuser,   // [0] op
  input  q_status_t             q_status,
  output logic                  push,
  output cmd_t                  push_cmd
);

  logic                led_r, led_nxt;
  logic [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [BYTE_W-1:0]   rx_byte;
  logic [SAMPLE_W-1:0] sample_in;
  logic                xfer;

  assign rx_byte   = in_tdata[BYTE_W-1:0];
  assign sample_in = in_tdata[BYTE_W +: SAMPLE_W];
  assign in_tready = !q_status.full;
  assign xfer      = in_tvalid && in_tready;
  assign push      = xfer;

  // Classify the item and work out the new state
  always_comb begin
    led_nxt        = led_r;
    sample_nxt     = sample_r;
    push_cmd.kind  = KIND_NONE;
    if (in_tuser == OP_SAMPLE) begin
      sample_nxt = sample_in;
    end else begin
      case (rx_byte)
        CH_ONE:   led_nxt = 1'b1;
        CH_ZERO:  led_nxt = 1'b0;
        CH_QUERY: push_cmd.kind = KIND_FLAG;
        CH_UPPL:  push_cmd.kind = KIND_NUM;
        CH_LOWL:  push_cmd.kind = KIND_NUM;
        default:  push_cmd.kind = KIND_NONE;
      endcase
    end
    push_cmd.led   = led_nxt;
    push_cmd.value = sample_nxt;
  end

  // State registers, updated on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_r    <= 1'b0;
      sample_r <= '0;
    end else if (xfer) begin
      led_r    <= led_nxt;
      sample_r <= sample_nxt;
    end
  end

endmodule

// ===== sv/scr_queue.sv =====
// Short command queue between the front and back ends.
// Register-based FIFO of QDEPTH entries; uses scr_pkg.
module scr_queue import scr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t status
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign head         = mem_r[rd_ptr_r];
  assign status.full  = (count_r == QCNT_W'(QDEPTH));
  assign status.empty = (count_r == '0);

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== sv/scr_back.sv =====
// Back end: pops commands, converts the sample to decimal one digit per
// cycle, and drives the registered result stream. Uses scr_pkg.
module scr_back import scr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   head,
  input  q_status_t              q_status,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] tx_byte, [8] led_on
  output logic                   out_tuser,  // [0] tx_valid
  output logic                   out_tlast
);

  bk_state_t state_r, state_nxt;

  logic [SAMPLE_W-1:0] val_r, val_nxt;
  logic [DCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                led_r, led_nxt;
  logic [DIGIT_W-1:0]  digit_r [NDIGITS];

  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_byte_r, out_byte_nxt;
  logic               out_led_r, out_led_nxt;
  logic               out_txv_r, out_txv_nxt;
  logic               out_last_r, out_last_nxt;

  logic                out_free;
  logic                load_out;
  logic                conv_en;
  logic [PROD_W-1:0]   prod;
  logic [QUOT_W-1:0]   quot;
  logic [SAMPLE_W-1:0] rem_full;
  logic [DIGIT_W-1:0]  rem;
  logic [DIDX_W-1:0]   emit_idx;

  assign out_free = !out_valid_r || out_tready;

  // Divide by ten: reciprocal multiply, then remainder by shift-and-subtract
  assign prod     = PROD_W'(val_r) * PROD_W'(DIV10_MUL);
  assign quot     = prod[PROD_W-1:DIV10_SHIFT];
  assign rem_full = val_r - (SAMPLE_W'(quot) << 3) - (SAMPLE_W'(quot) << 1);
  assign rem      = rem_full[DIGIT_W-1:0];
  assign emit_idx = DIDX_W'(cnt_r - 1'b1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_status.empty && head.kind == KIND_NUM) begin
          state_nxt = BK_CONV;
        end
      end
      BK_CONV: begin
        if (quot == '0) begin
          state_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free && cnt_r == DCNT_W'(1)) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Datapath controls and result values
  always_comb begin
    pop          = 1'b0;
    load_out     = 1'b0;
    conv_en      = 1'b0;
    val_nxt      = val_r;
    cnt_nxt      = cnt_r;
    led_nxt      = led_r;
    out_byte_nxt = out_byte_r;
    out_led_nxt  = out_led_r;
    out_txv_nxt  = out_txv_r;
    out_last_nxt = out_last_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_status.empty) begin
          if (head.kind == KIND_NUM) begin
            pop     = 1'b1;
            val_nxt = head.value;
            cnt_nxt = '0;
            led_nxt = head.led;
          end else if (out_free) begin
            pop          = 1'b1;
            load_out     = 1'b1;
            out_led_nxt  = head.led;
            out_last_nxt = 1'b1;
            if (head.kind == KIND_FLAG) begin
              out_txv_nxt  = 1'b1;
              out_byte_nxt = head.led ? CH_ONE : CH_ZERO;
            end else begin
              out_txv_nxt  = 1'b0;
              out_byte_nxt = '0;
            end
          end
        end
      end
      BK_CONV: begin
        conv_en = 1'b1;
        val_nxt = SAMPLE_W'(quot);
        cnt_nxt = cnt_r + 1'b1;
      end
      BK_EMIT: begin
        if (out_free) begin
          load_out     = 1'b1;
          out_txv_nxt  = 1'b1;
          out_byte_nxt = CH_ZERO + BYTE_W'(digit_r[emit_idx]);
          out_led_nxt  = led_r;
          out_last_nxt = (cnt_r == DCNT_W'(1));
          cnt_nxt      = cnt_r - 1'b1;
        end
      end
      default: ;
    endcase
    out_valid_nxt = load_out ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    led_r      <= led_nxt;
    out_byte_r <= out_byte_nxt;
    out_led_r  <= out_led_nxt;
    out_txv_r  <= out_txv_nxt;
    out_last_r <= out_last_nxt;
    if (conv_en) begin
      digit_r[cnt_r[DIDX_W-1:0]] <= rem;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_txv_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_TDATA_W - BYTE_W - 1){1'b0}}, out_led_r, out_byte_r};

endmodule
